// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/nrfh_pkg.sv =====
// shared types and constants for the netlist record fingerprint hash
package nrfh_pkg;

    localparam int unsigned HASH_W    = 64;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MAX_BYTES = 10;
    localparam int unsigned SEQ_W     = MAX_BYTES * BYTE_W;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned TDATA_W   = 168;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

    // request codes carried in tuser
    localparam logic [KIND_W-1:0] REQ_BEGIN      = 3'd0;
    localparam logic [KIND_W-1:0] REQ_COUNT      = 3'd1;
    localparam logic [KIND_W-1:0] REQ_NET        = 3'd2;
    localparam logic [KIND_W-1:0] REQ_CELL_HEAD  = 3'd3;
    localparam logic [KIND_W-1:0] REQ_CELL_INPUT = 3'd4;
    localparam logic [KIND_W-1:0] REQ_CELL_PARAM = 3'd5;

    // byte count of a begin record
    localparam logic [CNT_W-1:0] BEGIN_BYTES = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0] req_type;
        logic [WORD_W-1:0] word_value;
        logic [7:0]        radix_code;
        logic [7:0]        port_flag;
        logic [WORD_W-1:0] net_ref;
        logic [7:0]        cell_kind;
        logic [7:0]        input_count;
        logic              vacant;
        logic [HASH_W-1:0] param_value;
    } t_item;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic             left_zero;
        logic [CNT_W-1:0] left;
    } t_dp_status;

endpackage

// ===== rtl/nrfh_ctrl.sv =====
// controller state machine: item intake, byte stepping, result hand-off
module nrfh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    output nrfh_pkg::t_dp_cmd   o_cmd,
    input  nrfh_pkg::t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_ABSORB = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   w_out_free;

    assign w_out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ABSORB;
                end
            end
            S_ABSORB: begin
                if (!i_status.left_zero) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.publish) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

endmodule

// ===== rtl/nrfh_datapath.sv =====
// datapath: byte sequence register, fnv-1a round, running hash and result register
module nrfh_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [nrfh_pkg::WORD_W-1:0]  i_cfg_wr_data,
    input  nrfh_pkg::t_item              i_item,
    input  nrfh_pkg::t_dp_cmd            i_cmd,
    output nrfh_pkg::t_dp_status         o_status,
    output logic [nrfh_pkg::HASH_W-1:0]  o_digest
);

    logic [nrfh_pkg::SEQ_W-1:0]  r_seq, n_seq;
    logic [nrfh_pkg::CNT_W-1:0]  r_left, n_left;
    logic [nrfh_pkg::HASH_W-1:0] r_hash, n_hash;
    logic [nrfh_pkg::WORD_W-1:0] r_version;
    logic [nrfh_pkg::HASH_W-1:0] r_dout;

    logic [nrfh_pkg::SEQ_W-1:0]  w_load_seq;
    logic [nrfh_pkg::CNT_W-1:0]  w_load_cnt;
    logic [nrfh_pkg::HASH_W-1:0] w_mix;
    logic [nrfh_pkg::HASH_W-1:0] w_round;

    // serialise one record into bytes, lowest byte absorbed first
    always_comb begin
        w_load_seq = '0;
        w_load_cnt = '0;
        unique case (i_item.req_type)
            nrfh_pkg::REQ_BEGIN: begin
                w_load_seq = {16'h0, r_version, 8'h31, 8'h48, 8'h4b, 8'h54};
                w_load_cnt = nrfh_pkg::BEGIN_BYTES;
            end
            nrfh_pkg::REQ_COUNT, nrfh_pkg::REQ_CELL_INPUT: begin
                w_load_seq = {48'h0, i_item.word_value};
                w_load_cnt = 4'd4;
            end
            nrfh_pkg::REQ_NET: begin
                w_load_seq = {i_item.net_ref, i_item.port_flag, i_item.radix_code,
                              i_item.word_value};
                w_load_cnt = 4'd10;
            end
            nrfh_pkg::REQ_CELL_HEAD: begin
                if (i_item.vacant) begin
                    w_load_seq = '0;
                    w_load_cnt = 4'd1;
                end else begin
                    w_load_seq = {i_item.input_count, i_item.net_ref,
                                  i_item.word_value, i_item.cell_kind};
                    w_load_cnt = 4'd10;
                end
            end
            nrfh_pkg::REQ_CELL_PARAM: begin
                w_load_seq = {16'h0, i_item.param_value};
                w_load_cnt = 4'd8;
            end
            default: begin
                w_load_seq = '0;
                w_load_cnt = '0;
            end
        endcase
    end

    // one fnv-1a round: xor byte, multiply by 0x100000001b3 as shift-add
    assign w_mix   = r_hash ^ {56'h0, r_seq[nrfh_pkg::BYTE_W-1:0]};
    assign w_round = w_mix + (w_mix << 1) + (w_mix << 4) + (w_mix << 5)
                   + (w_mix << 7) + (w_mix << 8) + (w_mix << 40);

    always_comb begin
        n_seq  = r_seq;
        n_left = r_left;
        n_hash = r_hash;
        if (i_cmd.load) begin
            n_seq  = w_load_seq;
            n_left = w_load_cnt;
            if (i_item.req_type == nrfh_pkg::REQ_BEGIN) begin
                n_hash = nrfh_pkg::FNV_BASIS;
            end
        end else if (i_cmd.step) begin
            n_seq  = r_seq >> nrfh_pkg::BYTE_W;
            n_left = r_left - 4'd1;
            n_hash = w_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_hash    <= nrfh_pkg::FNV_BASIS;
            r_version <= 32'd1;
        end else begin
            r_left <= n_left;
            r_hash <= n_hash;
            if (i_cfg_wr_en) begin
                r_version <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq <= n_seq;
        if (i_cmd.publish) begin
            r_dout <= r_hash;
        end
    end

    assign o_status.left      = r_left;
    assign o_status.left_zero = (r_left == '0);
    assign o_digest           = r_dout;

endmodule

// ===== rtl/netlist_record_fingerprint_hash.sv =====
// top level of the netlist record fingerprint hash (64-bit fnv-1a)
// usage
//   slave stream carries one netlist record per item: tuser holds the request
//   kind (begin, count, net, cell head, cell input, cell param), tdata the
//   record fields. master stream returns the running 64-bit digest after
//   every item, one result item per input item, in order.
//   the version word absorbed at begin resets to 1; the user must write it via
//   i_cfg_wr_en/i_cfg_wr_data only while the block is idle (not enforced here).
// timing
//   each record is serialised into up to ten bytes and one byte is absorbed
//   per cycle through a single fnv round (xor, then constant multiply done as
//   shift-add). an item holds the block for its load, one round per byte and
//   the hand-off, which waits while an earlier result is unread. a net or full
//   cell head has ten bytes, begin or param eight, count or input four.
//   unused request codes absorb nothing and return the hash unchanged.
// reset
//   synchronous, active low: hash goes to the offset basis, no result pending.
// back-pressure
//   the digest sits in an output register; the next item is taken while it
//   waits, and only the hand-off of that next item stalls until it is read.
`include "assert_macros.svh"

module netlist_record_fingerprint_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: format_version
    input  logic                          i_cfg_wr_en,
    input  logic [nrfh_pkg::WORD_W-1:0]   i_cfg_wr_data,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, low bit up: word_value[31:0], radix_code[39:32], port_flag[47:40],
    // net_ref[79:48], cell_kind[87:80], input_count[95:88], vacant[96],
    // param_value[160:97], zero fill[167:161]
    input  logic [nrfh_pkg::TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [nrfh_pkg::KIND_W-1:0]   s_axis_tuser,
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: digest[63:0]
    output logic [nrfh_pkg::HASH_W-1:0]   m_axis_tdata
);

    nrfh_pkg::t_item      w_item;
    nrfh_pkg::t_dp_cmd    w_cmd;
    nrfh_pkg::t_dp_status w_status;
    logic                 w_in_accept;

    // unpack the record fields from the stream
    assign w_item.req_type    = s_axis_tuser;
    assign w_item.word_value  = s_axis_tdata[31:0];
    assign w_item.radix_code  = s_axis_tdata[39:32];
    assign w_item.port_flag   = s_axis_tdata[47:40];
    assign w_item.net_ref     = s_axis_tdata[79:48];
    assign w_item.cell_kind   = s_axis_tdata[87:80];
    assign w_item.input_count = s_axis_tdata[95:88];
    assign w_item.vacant      = s_axis_tdata[96];
    assign w_item.param_value = s_axis_tdata[160:97];

    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    // sequencer: decides load, byte rounds and result hand-off
    nrfh_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd),
        .i_status  (w_status)
    );

    // hash datapath with the version register and the result register
    nrfh_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (w_item),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_digest      (m_axis_tdata)
    );

    // intake only once the previous record has been fully absorbed
    `ASSERT_IMPLY(a_ready_only_when_drained, i_clk, i_rst_n, s_axis_tready, w_status.left_zero)
    // one item at a time: intake closes right after an acceptance
    `ASSERT_NEXT(a_single_item_in_flight, i_clk, i_rst_n, w_in_accept, !s_axis_tready)
    // a begin record queues the four magic bytes and the version word
    `ASSERT_NEXT(a_begin_byte_count, i_clk, i_rst_n,
        w_in_accept && (s_axis_tuser == nrfh_pkg::REQ_BEGIN),
        w_status.left == nrfh_pkg::BEGIN_BYTES)

endmodule
